>>> rtl/dgl_pkg.sv
// dgl_pkg: shared widths, constants, controller states and the command and
// status structs of the dithered gradient line generator.
// No dependencies.
`default_nettype none

package dgl_pkg;

  localparam int COLOR_W     = 32;
  localparam int COUNT_W     = 7;
  localparam int S_TDATA_W   = 72;
  localparam int M_TDATA_W   = 32;
  localparam int CHANNELS    = 4;
  localparam int DIV_STEPS   = 24;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam int MAX_LINE_PIXELS_DEFAULT = 64;

  localparam logic [31:0] LCG_MUL      = 32'd1664525;
  localparam logic [31:0] LCG_ADD      = 32'd1013904223;
  localparam logic [31:0] SEED_RESET   = 32'd2147483563;
  localparam logic [15:0] DITHER_SCALE = 16'h0101;

  // generator value used for the first pixel after reset
  localparam logic [31:0] SEED_FIRST = 32'(SEED_RESET * LCG_MUL + LCG_ADD);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic req_empty;
    logic req_single;
    logic div_last;
    logic pixel_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/dgl_ctrl.sv
// dgl_ctrl: controller state machine of the gradient line generator.
// Depends on dgl_pkg for the state, command and status types.
`default_nettype none

module dgl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  dgl_pkg::status_t status,
  output dgl_pkg::cmd_t    cmd
);
  import dgl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (status.req_empty) begin
            state_next = ST_IDLE;
          end else if (status.req_single) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.pixel_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.div_en = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // input stays closed while reset is held
        s_tready = !rst;
        cmd.load = s_tvalid && !rst;
      end
      ST_DIVIDE: begin
        cmd.div_en = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dgl_datapath.sv
// dgl_datapath: request decode, four-lane restoring divider, channel
// accumulators, dither generator and output register.
// Depends on dgl_pkg for widths, constants and the command and status types.
`default_nettype none

module dgl_datapath #(
  parameter int MAX_LINE_PIXELS = dgl_pkg::MAX_LINE_PIXELS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dgl_pkg::cmd_t                   cmd,
  output dgl_pkg::status_t                status,
  input  logic [dgl_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dgl_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                            m_tlast
);
  import dgl_pkg::*;

  logic [COLOR_W-1:0]   start_color;
  logic [COLOR_W-1:0]   end_color;
  logic [COUNT_W-1:0]   pixel_count;
  logic [COUNT_W-1:0]   count_sat;

  logic [COUNT_W-1:0]   divisor;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [COUNT_W-1:0]   pixels_left;
  logic [31:0]          dither_seed;
  logic [31:0]          pixel_next;

  assign start_color = s_tdata[31:0];
  assign end_color   = s_tdata[63:32];
  assign pixel_count = s_tdata[70:64];

  // requests above the line limit are clamped to it
  assign count_sat = (pixel_count > COUNT_W'(MAX_LINE_PIXELS)) ?
                     COUNT_W'(MAX_LINE_PIXELS) : pixel_count;

  assign status.req_empty  = (count_sat == '0);
  assign status.req_single = (count_sat == COUNT_W'(1));
  assign status.div_last   = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign status.pixel_last = (pixels_left == COUNT_W'(1));
  assign status.out_free   = !m_tvalid || m_tready;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic [7:0]            s_byte;
    logic [7:0]            e_byte;
    logic [7:0]            mag;
    logic                  neg_in;
    logic [31:0]           diff_full;
    logic [31:0]           acc;
    logic [31:0]           step;
    logic [COUNT_W-1:0]    rem;
    logic [DIV_STEPS-1:0]  quo;
    logic                  neg;
    logic [COUNT_W:0]      trial;
    logic                  fits;
    logic [COUNT_W-1:0]    rem_next;
    logic [DIV_STEPS-1:0]  quo_next;
    logic [31:0]           quo_ext;
    logic [7:0]            dith_byte;
    logic [23:0]           dith_sum;

    assign s_byte    = start_color[31-8*i -: 8];
    assign e_byte    = end_color[31-8*i -: 8];
    assign neg_in    = (s_byte > e_byte);
    assign mag       = neg_in ? (s_byte - e_byte) : (e_byte - s_byte);
    assign diff_full = {8'd0, e_byte, 16'd0} - {8'd0, s_byte, 16'd0};

    // one quotient bit per cycle, dividend shifts out of quo as bits shift in
    assign trial    = {rem, quo[DIV_STEPS-1]};
    assign fits     = (trial >= {1'b0, divisor});
    assign rem_next = fits ? COUNT_W'(trial - {1'b0, divisor}) : trial[COUNT_W-1:0];
    assign quo_next = {quo[DIV_STEPS-2:0], fits};
    assign quo_ext  = {{(32-DIV_STEPS){1'b0}}, quo_next};

    assign dith_byte = dither_seed[31-8*i -: 8];
    assign dith_sum  = acc[23:0] + 24'(dith_byte * DITHER_SCALE);
    assign pixel_next[31-8*i -: 8] = dith_sum[23:16];

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        acc  <= {8'd0, s_byte, 16'd0};
        step <= diff_full;
        rem  <= '0;
        quo  <= {mag, 16'd0};
        neg  <= neg_in;
      end else if (cmd.div_en) begin
        rem <= rem_next;
        quo <= quo_next;
        if (status.div_last) begin
          step <= neg ? (32'd0 - quo_ext) : quo_ext;
        end
      end else if (cmd.emit) begin
        acc <= acc + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor <= count_sat - COUNT_W'(1);
    end
    if (cmd.emit) begin
      m_tdata <= pixel_next;
      m_tlast <= status.pixel_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt     <= '0;
      pixels_left <= '0;
      dither_seed <= SEED_FIRST;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        div_cnt     <= '0;
        pixels_left <= count_sat;
      end else if (cmd.div_en) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end else if (cmd.emit) begin
        pixels_left <= pixels_left - COUNT_W'(1);
      end
      // seed register already holds the advanced value for the next pixel
      if (cmd.emit) begin
        dither_seed <= dither_seed * LCG_MUL + LCG_ADD;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/dithered_gradient_line.sv
// dithered_gradient_line: top level, controller plus datapath.
// Depends on dgl_pkg, dgl_ctrl and dgl_datapath.
`default_nettype none

// A line request carries a start and an end ARGB color and a pixel count;
// the block answers with that many dithered ARGB pixels, interpolated per
// channel in 16.16 fixed point, with tlast on the final pixel. Counts above
// MAX_LINE_PIXELS are clamped, a count of zero produces no pixel. A request
// of n pixels is taken in the idle state; when n is two or more the
// restoring divider then works out the per-channel step (all four channels
// in parallel, one quotient bit per cycle), then the block sends one pixel
// per cycle while the output is taken. For n = 1 the divider is skipped.
// The dither generator runs on across lines and restarts only at reset.
module dithered_gradient_line #(
  parameter int MAX_LINE_PIXELS = dgl_pkg::MAX_LINE_PIXELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // start_color [31:0], end_color [63:32], pixel_count [70:64], zero [71]
  input  logic [dgl_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pixel_value [31:0]
  output logic [dgl_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import dgl_pkg::*;

  cmd_t    cmd;
  status_t status;

  dgl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dgl_datapath #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

>>> rtl/dgl_checker.sv
// dgl_checker: port-level assertions for dithered_gradient_line, bound to it.
// Depends on dgl_pkg for the port widths.
`default_nettype none

module dgl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [dgl_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dgl_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast
);
  import dgl_pkg::*;

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // a request with pixels closes the input once it is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[70:64] != 7'd0) |=> !s_tready)
    else $error("input open right after a nonempty request");

  // an empty request leaves the input open
  a_empty_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[70:64] == 7'd0) |=> s_tready)
    else $error("input closed after an empty request");

  // mid-line pixels go out only while the input is closed
  a_mid_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("input open in the middle of a line");

endmodule

bind dithered_gradient_line dgl_checker u_checker (.*);

`default_nettype wire
